// ===== rtl/npufb_pkg.sv =====
// Shared types, constants and helpers for the NTP/PTP UDP frame builder.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package npufb_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int IDENT_W  = 64;
    localparam int PORT_W   = 16;
    localparam int WORD_W   = 32;
    localparam int VB_W     = 3;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = 5;
    localparam int CSUM_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    localparam int S_TDATA_W = IP_W + 2 * IDENT_W + PORT_W;
    localparam int M_FIELD_W = WORD_W + VB_W + LEN_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DEST_IP    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PKT_MODE   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_PTP_DOMAIN = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_PTP_MCAST  = CFG_IDX_W'(5);

    localparam logic [1:0] MODE_NTP_BASIC  = 2'd0;
    localparam logic [1:0] MODE_NTP_ILEAVE = 2'd1;
    localparam logic [1:0] MODE_PTP_DREQ   = 2'd2;
    localparam logic [1:0] MODE_PTP_NSM    = 2'd3;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] IP_VER_TOS     = 16'h4500;
    localparam logic [15:0] IP_IDENT       = 16'hd7e9;
    localparam logic [15:0] IP_FLAGS_FRAG  = 16'h4000;
    localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;
    localparam logic [7:0]  NTP_LI_VN_MODE = 8'he3;
    localparam logic [31:0] PTP_NSM_TLV    = 32'h21fe_0000;
    localparam logic [15:0] PTP_MSG_VER    = 16'h0102;
    localparam logic [7:0]  PTP_UNICAST    = 8'h04;
    localparam logic [7:0]  PTP_CTRL_DREQ  = 8'h01;
    localparam logic [15:0] PTP_PORT       = 16'd319;
    localparam logic [15:0] NTP_PORT       = 16'd123;

    localparam logic [15:0] IP_LEN_LONG   = 16'd76;
    localparam logic [15:0] IP_LEN_SHORT  = 16'd72;
    localparam logic [15:0] UDP_LEN_LONG  = 16'd56;
    localparam logic [15:0] UDP_LEN_SHORT = 16'd52;
    localparam logic [15:0] PTP_LEN_LONG  = 16'd48;
    localparam logic [15:0] PTP_LEN_SHORT = 16'd44;
    localparam logic [LEN_W-1:0] FRAME_LEN_LONG  = LEN_W'(90);
    localparam logic [LEN_W-1:0] FRAME_LEN_SHORT = LEN_W'(86);
    localparam logic [IDX_W-1:0] LAST_IDX_LONG   = IDX_W'(22);
    localparam logic [IDX_W-1:0] LAST_IDX_SHORT  = IDX_W'(21);
    localparam logic [VB_W-1:0]  VB_FULL = VB_W'(4);
    localparam logic [VB_W-1:0]  VB_TAIL = VB_W'(2);

    typedef struct packed {
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] source_mac;
        logic [IP_W-1:0]  dest_ip;
        logic [1:0]       packet_mode;
        logic [7:0]       ptp_domain_number;
        logic             ptp_multicast;
    } cfg_t;

    typedef struct packed {
        logic [IP_W-1:0]    source_ip;
        logic [IDENT_W-1:0] local_ident;
        logic [IDENT_W-1:0] remote_ident;
        logic [PORT_W-1:0]  udp_source_port;
        logic [CSUM_W-1:0]  ip_csum;
    } req_t;

    function automatic logic [IDENT_W-1:0] byte_swap64(input logic [IDENT_W-1:0] v);
        logic [IDENT_W-1:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

    function automatic logic is_ptp_short(input logic [1:0] mode);
        return mode == MODE_PTP_DREQ;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/npufb_req_buf.sv =====
// Request holding register with IPv4 header checksum precompute.
// Depends on npufb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npufb_req_buf import npufb_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [S_TDATA_W-1:0] in_data,
    output logic                      hold_valid,
    input  wire logic                 hold_take,
    output req_t                      hold_req
);

    logic        hold_valid_reg, hold_valid_next;
    req_t        hold_req_reg;
    logic [19:0] sum_wide;
    logic [16:0] sum_fold;
    logic [15:0] sum_final;
    logic [15:0] ip_len;
    logic [IP_W-1:0] src_ip;

    assign src_ip = in_data[IP_W-1:0];
    assign ip_len = is_ptp_short(cfg.packet_mode) ? IP_LEN_SHORT : IP_LEN_LONG;

    always_comb begin
        sum_wide = 20'(IP_VER_TOS) + 20'(ip_len) + 20'(IP_IDENT) + 20'(IP_FLAGS_FRAG)
                 + 20'(IP_TTL_PROTO) + 20'(src_ip[31:16]) + 20'(src_ip[15:0])
                 + 20'(cfg.dest_ip[31:16]) + 20'(cfg.dest_ip[15:0]);
        sum_fold  = 17'(sum_wide[15:0]) + 17'(sum_wide[19:16]);
        sum_final = sum_fold[15:0] + 16'(sum_fold[16]);
    end

    assign in_ready = !hold_valid_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (hold_take) begin
            hold_valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_req_reg.source_ip       <= src_ip;
            hold_req_reg.local_ident     <= in_data[IP_W +: IDENT_W];
            hold_req_reg.remote_ident    <= in_data[IP_W + IDENT_W +: IDENT_W];
            hold_req_reg.udp_source_port <= in_data[IP_W + 2*IDENT_W +: PORT_W];
            hold_req_reg.ip_csum         <= ~sum_final;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_req   = hold_req_reg;

endmodule

`default_nettype wire

// ===== rtl/npufb_word_mux.sv =====
// Frame word selection: builds one 32-bit frame word from the word index.
// Depends on npufb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npufb_word_mux import npufb_pkg::*; (
    input  wire cfg_t             cfg,
    input  wire req_t             req,
    input  wire logic [IDX_W-1:0] idx,
    output logic [WORD_W-1:0]     word,
    output logic [VB_W-1:0]       valid_bytes,
    output logic [LEN_W-1:0]      frame_length,
    output logic                  last_word
);

    logic              ntp, nsm, shrt;
    logic [15:0]       sport, dport, ip_len, udp_len, ptp_len;
    logic [7:0]        flags;
    logic [IDENT_W-1:0] rem_le, rcv_le, loc_le;
    logic [IP_W-1:0]   sip;

    assign ntp     = (cfg.packet_mode == MODE_NTP_BASIC) || (cfg.packet_mode == MODE_NTP_ILEAVE);
    assign nsm     = cfg.packet_mode == MODE_PTP_NSM;
    assign shrt    = is_ptp_short(cfg.packet_mode);
    assign sport   = ntp ? req.udp_source_port : PTP_PORT;
    assign dport   = ntp ? NTP_PORT : PTP_PORT;
    assign ip_len  = shrt ? IP_LEN_SHORT : IP_LEN_LONG;
    assign udp_len = shrt ? UDP_LEN_SHORT : UDP_LEN_LONG;
    assign ptp_len = shrt ? PTP_LEN_SHORT : PTP_LEN_LONG;
    assign flags   = cfg.ptp_multicast ? 8'h00 : PTP_UNICAST;
    assign rem_le  = byte_swap64(req.remote_ident);
    assign rcv_le  = byte_swap64(req.local_ident ^ IDENT_W'(1));
    assign loc_le  = byte_swap64(req.local_ident);
    assign sip     = req.source_ip;

    always_comb begin
        word = '0;
        case (idx)
            5'd0:  word = cfg.dest_mac[47:16];
            5'd1:  word = {cfg.dest_mac[15:0], cfg.source_mac[47:32]};
            5'd2:  word = cfg.source_mac[31:0];
            5'd3:  word = {ETHERTYPE_IPV4, IP_VER_TOS};
            5'd4:  word = {ip_len, IP_IDENT};
            5'd5:  word = {IP_FLAGS_FRAG, IP_TTL_PROTO};
            5'd6:  word = {req.ip_csum, sip[31:16]};
            5'd7:  word = {sip[15:0], cfg.dest_ip[31:16]};
            5'd8:  word = {cfg.dest_ip[15:0], sport};
            5'd9:  word = {dport, udp_len};
            5'd10: word = ntp ? {16'h0000, NTP_LI_VN_MODE, 8'h00} : {16'h0000, PTP_MSG_VER};
            5'd11: word = ntp ? 32'h0 : {ptp_len, cfg.ptp_domain_number, 8'h00};
            5'd12: word = ntp ? 32'h0 : {flags, 24'h0};
            5'd15: word = ntp ? 32'h0 : {16'h0000, sip[31:16]};
            5'd16: word = ntp ? {16'h0000, rem_le[63:48]} : {sip[15:0], 16'h0000};
            5'd17: word = ntp ? rem_le[47:16] : 32'h0;
            5'd18: word = ntp ? {rem_le[15:0], rcv_le[63:48]}
                              : {loc_le[63:48], PTP_CTRL_DREQ, 8'h00};
            5'd19: word = ntp ? rcv_le[47:16] : 32'h0;
            5'd20: word = ntp ? {rcv_le[15:0], loc_le[63:48]} : 32'h0;
            5'd21: word = ntp ? loc_le[47:16] : (nsm ? {16'h0000, PTP_NSM_TLV[31:16]} : 32'h0);
            5'd22: word = ntp ? {loc_le[15:0], 16'h0000} : {PTP_NSM_TLV[15:0], 16'h0000};
            default: word = '0;
        endcase
    end

    assign last_word    = idx == (shrt ? LAST_IDX_SHORT : LAST_IDX_LONG);
    assign valid_bytes  = last_word ? VB_TAIL : VB_FULL;
    assign frame_length = shrt ? FRAME_LEN_SHORT : FRAME_LEN_LONG;

endmodule

`default_nettype wire

// ===== rtl/npufb_emitter.sv =====
// Word sequencer: current request, word counter and output register.
// Depends on npufb_pkg and npufb_word_mux.
`timescale 1ns / 1ps
`default_nettype none

module npufb_emitter import npufb_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 hold_valid,
    output logic                      hold_take,
    input  wire req_t                 hold_req,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [M_TDATA_W-1:0]      out_data,
    output logic                      out_last
);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    req_t             cur_reg;
    logic             out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic             out_last_reg;
    logic             advance;
    logic [WORD_W-1:0] word;
    logic [VB_W-1:0]   vb;
    logic [LEN_W-1:0]  flen;
    logic              last;

    npufb_word_mux u_word_mux (
        .cfg          (cfg),
        .req          (cur_reg),
        .idx          (cnt_reg),
        .word         (word),
        .valid_bytes  (vb),
        .frame_length (flen),
        .last_word    (last)
    );

    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign hold_take = hold_valid && (!busy_reg || (advance && last));

    always_comb begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            if (last) begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
        end
        if (hold_take) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_take) begin
            cur_reg <= hold_req;
        end
        if (advance) begin
            out_data_reg <= M_TDATA_W'({flen, vb, word});
            out_last_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/ntp_ptp_udp_frame_builder_top.sv =====
// A request passes the request holding register, the emitter's current-request register and the
// output register before its first frame word appears. Throughput: one word per cycle while
// m_tready is not held low; 23 words per NTP or PTP NSM frame, 22 per PTP delay request, set by
// the word counter of the emitter. One request is held while the previous frame is being sent.
// Reset: synchronous active-low aresetn clears configuration and control state, drops the frame.
// Depends on npufb_pkg, npufb_req_buf, npufb_emitter.
`timescale 1ns / 1ps
`default_nettype none

module ntp_ptp_udp_frame_builder_top import npufb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // source_ip, local_ident, remote_ident, udp_source_port
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // frame_word, valid_bytes, frame_length, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast
);

    cfg_t cfg_reg, cfg_next;
    logic hold_valid, hold_take;
    req_t hold_req;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEST_MAC:   cfg_next.dest_mac          = cfg_data[MAC_W-1:0];
                REG_SOURCE_MAC: cfg_next.source_mac        = cfg_data[MAC_W-1:0];
                REG_DEST_IP:    cfg_next.dest_ip           = cfg_data[IP_W-1:0];
                REG_PKT_MODE:   cfg_next.packet_mode       = cfg_data[1:0];
                REG_PTP_DOMAIN: cfg_next.ptp_domain_number = cfg_data[7:0];
                REG_PTP_MCAST:  cfg_next.ptp_multicast     = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    npufb_req_buf u_req_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .hold_valid (hold_valid),
        .hold_take  (hold_take),
        .hold_req   (hold_req)
    );

    npufb_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .hold_valid (hold_valid),
        .hold_take  (hold_take),
        .hold_req   (hold_req),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/ntp_ptp_udp_frame_builder_top_tb.sv =====
// Self-checking testbench for the NTP/PTP UDP frame builder: a directed table, then random
// requests over several register settings, each output word scored against a local frame model.
// Depends on npufb_pkg and ntp_ptp_udp_frame_builder_top.
`timescale 1ns / 1ps
`default_nettype none

module ntp_ptp_udp_frame_builder_top_tb;
    import npufb_pkg::*;

    localparam logic [15:0] ETH_TYPE_IP    = 16'h0800;
    localparam logic [15:0] IPV4_VER_IHL   = 16'h4500;
    localparam logic [15:0] IPV4_ID        = 16'hd7e9;
    localparam logic [15:0] IPV4_DF        = 16'h4000;
    localparam logic [15:0] IPV4_TTL_UDP   = 16'h4011;
    localparam logic [7:0]  NTP_HDR_BYTE   = 8'he3;
    localparam logic [15:0] PTP_TYPE_VER   = 16'h0102;
    localparam logic [31:0] NSM_TLV_WORD   = 32'h21fe_0000;
    localparam logic [7:0]  PTP_FLAG_UCAST = 8'h04;
    localparam logic [7:0]  PTP_CTRL_BYTE  = 8'h01;
    localparam logic [15:0] UDP_PORT_PTP   = 16'd319;
    localparam logic [15:0] UDP_PORT_NTP   = 16'd123;
    localparam logic [7:0]  REG_UNUSED_LO  = 8'd6;
    localparam logic [6:0]  LEN_NONE       = 7'd0;
    localparam int          N_DIR          = 14;
    localparam int          N_PHASES       = 8;
    localparam int          PHASE_ITEMS    = 50;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [63:0] local_ident;
        logic [63:0] remote_ident;
        logic [15:0] udp_source_port;
    } request_t;

    typedef struct packed {
        cfg_t        cfg;
        request_t    req;
        logic [6:0]  flen;
    } dir_row_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic [6:0]  flen;
        logic        last;
    } frame_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // source_ip, local_ident, remote_ident, udp_source_port
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // frame_word, valid_bytes, frame_length, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    cfg_t        regs_now = '0;
    frame_word_t frame_words_due[$];
    frame_word_t due_word;
    int          mismatches = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    dir_row_t dir_table [0:N_DIR-1] = '{
        // dest_mac, source_mac, dest_ip, mode, domain, mcast |
        // source_ip, local_ident, remote_ident, udp_source_port | frame length
        {48'h0, 48'h0, 32'h0, MODE_NTP_BASIC, 8'h00, 1'b0,
         32'h0, 64'h0, 64'h0, 16'h0000, 7'd90},
        {48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, MODE_NTP_BASIC, 8'hff, 1'b1,
         32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 16'hffff, 7'd90},
        {48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, MODE_NTP_ILEAVE, 8'hff, 1'b1,
         32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 16'hffff, 7'd90},
        {48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, MODE_PTP_DREQ, 8'hff, 1'b1,
         32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 16'hffff, 7'd86},
        {48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, MODE_PTP_NSM, 8'hff, 1'b1,
         32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 16'hffff, 7'd90},
        {48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, MODE_PTP_NSM, 8'h00, 1'b0,
         32'h0, 64'h0, 64'h0, 16'h0000, 7'd90},
        {48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, MODE_PTP_DREQ, 8'h00, 1'b0,
         32'h0, 64'h0, 64'h0, 16'h0000, 7'd86},
        {48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 32'hffff_ffff, MODE_PTP_DREQ, 8'h5a, 1'b0,
         32'hc0a8_0001, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 16'h9c40, LEN_NONE},
        {48'h0200_5e10_2030, 48'h0a0b_0c0d_0e0f, 32'h0a00_0001, MODE_NTP_BASIC, 8'h5a, 1'b0,
         32'h0a00_0002, 64'h1, 64'h8000_0000_0000_0000, 16'h8000, LEN_NONE},
        {48'h0200_5e10_2030, 48'h0a0b_0c0d_0e0f, 32'h0a00_0001, MODE_NTP_BASIC, 8'h5a, 1'b0,
         32'h0a00_0002, 64'hffff_ffff_ffff_fffe, 64'h1, 16'hed5f, LEN_NONE},
        {48'h0200_5e10_2030, 48'h0a0b_0c0d_0e0f, 32'h0a00_0001, MODE_NTP_ILEAVE, 8'h5a, 1'b0,
         32'hffff_0000, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 16'h7fff, LEN_NONE},
        {48'h0200_5e10_2030, 48'h0a0b_0c0d_0e0f, 32'h0a00_0001, MODE_PTP_NSM, 8'h80, 1'b0,
         32'h8000_0001, 64'h0000_0000_0000_ff00, 64'hdead_beef_cafe_f00d, 16'h1234, LEN_NONE},
        {48'h0200_5e10_2030, 48'h0a0b_0c0d_0e0f, 32'h0a00_0001, MODE_PTP_NSM, 8'h80, 1'b1,
         32'h8000_0001, 64'h0000_0000_0000_ff00, 64'hdead_beef_cafe_f00d, 16'h1234, LEN_NONE},
        {48'h0200_5e10_2030, 48'h0a0b_0c0d_0e0f, 32'hffff_ffff, MODE_NTP_BASIC, 8'h80, 1'b1,
         32'hffff_ffff, 64'h0f1e_2d3c_4b5a_6978, 64'h8796_a5b4_c3d2_e1f0, 16'hc000, LEN_NONE}
    };

    ntp_ptp_udp_frame_builder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] le_bytes(input logic [63:0] v);
        logic [63:0] r;
        int k;
        for (k = 0; k < 8; k++) begin
            r[8*k +: 8] = v[8*(7-k) +: 8];
        end
        return r;
    endfunction

    // Build the whole frame from the current registers and queue its words.
    function automatic void predict_frame(input request_t r, input logic [6:0] flen_typed);
        logic        is_ntp;
        logic [15:0] plen;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] sum;
        logic [15:0] csum;
        logic [383:0] payload;
        logic [735:0] f;
        int          total;
        int          nwords;
        int          i;
        frame_word_t e;
        is_ntp = (regs_now.packet_mode == MODE_NTP_BASIC) ||
                 (regs_now.packet_mode == MODE_NTP_ILEAVE);
        plen = (regs_now.packet_mode == MODE_PTP_DREQ) ? 16'd44 : 16'd48;
        sport = is_ntp ? r.udp_source_port : UDP_PORT_PTP;
        dport = is_ntp ? UDP_PORT_NTP : UDP_PORT_PTP;
        sum = 32'(IPV4_VER_IHL) + 32'(plen + 16'd28) + 32'(IPV4_ID) + 32'(IPV4_DF)
            + 32'(IPV4_TTL_UDP) + 32'(r.source_ip[31:16]) + 32'(r.source_ip[15:0])
            + 32'(regs_now.dest_ip[31:16]) + 32'(regs_now.dest_ip[15:0]);
        sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        csum = ~sum[15:0];
        if (is_ntp) begin
            payload = {NTP_HDR_BYTE, 184'h0, le_bytes(r.remote_ident),
                       le_bytes(r.local_ident ^ 64'h1), le_bytes(r.local_ident)};
        end else begin
            payload = {PTP_TYPE_VER, plen, regs_now.ptp_domain_number, 8'h00,
                       regs_now.ptp_multicast ? 8'h00 : PTP_FLAG_UCAST, 104'h0,
                       r.source_ip, 48'h0, r.local_ident[7:0], r.local_ident[15:8],
                       PTP_CTRL_BYTE, 88'h0,
                       (regs_now.packet_mode == MODE_PTP_NSM) ? NSM_TLV_WORD : 32'h0};
        end
        f = {regs_now.dest_mac, regs_now.source_mac, ETH_TYPE_IP,
             IPV4_VER_IHL, plen + 16'd28, IPV4_ID, IPV4_DF, IPV4_TTL_UDP, csum,
             r.source_ip, regs_now.dest_ip,
             sport, dport, plen + 16'd8, 16'h0,
             payload, 16'h0};
        total = 42 + int'(plen);
        nwords = (total + 3) / 4;
        for (i = 0; i < nwords; i++) begin
            e.word = f[735 - 32*i -: 32];
            e.last = (i == nwords - 1);
            e.nbytes = e.last ? 3'(total - 4*i) : 3'd4;
            e.flen = (flen_typed != LEN_NONE) ? flen_typed : 7'(total);
            frame_words_due.push_back(e);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_DEST_MAC:   regs_now.dest_mac = val;
            REG_SOURCE_MAC: regs_now.source_mac = val;
            REG_DEST_IP:    regs_now.dest_ip = val[31:0];
            REG_PKT_MODE:   regs_now.packet_mode = val[1:0];
            REG_PTP_DOMAIN: regs_now.ptp_domain_number = val[7:0];
            REG_PTP_MCAST:  regs_now.ptp_multicast = val[0];
            default: ;
        endcase
    endtask

    // Write the registers that differ, with fill above each width, then a random unused index.
    task automatic set_config(input cfg_t c, input logic [CFG_DATA_W-1:0] fill);
        logic [CFG_DATA_W-1:0] d;
        if (c.dest_mac != regs_now.dest_mac) write_reg(REG_DEST_MAC, c.dest_mac);
        if (c.source_mac != regs_now.source_mac) write_reg(REG_SOURCE_MAC, c.source_mac);
        if (c.dest_ip != regs_now.dest_ip) begin
            d = fill;
            d[31:0] = c.dest_ip;
            write_reg(REG_DEST_IP, d);
        end
        if (c.packet_mode != regs_now.packet_mode) begin
            d = fill;
            d[1:0] = c.packet_mode;
            write_reg(REG_PKT_MODE, d);
        end
        if (c.ptp_domain_number != regs_now.ptp_domain_number) begin
            d = fill;
            d[7:0] = c.ptp_domain_number;
            write_reg(REG_PTP_DOMAIN, d);
        end
        if (c.ptp_multicast != regs_now.ptp_multicast) begin
            d = fill;
            d[0] = c.ptp_multicast;
            write_reg(REG_PTP_MCAST, d);
        end
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, 8'hff)),
                  CFG_DATA_W'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    // Hold requests until every frame word is out, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frame_words_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_request(input request_t r, input logic [6:0] flen_typed);
        s_tvalid <= 1'b1;
        s_tdata <= {r.udp_source_port, r.remote_ident, r.local_ident, r.source_ip};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame(r, flen_typed);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_words_due.size() == 0) begin
                $error("frame_word: expected none, got %h", m_tdata[31:0]);
                mismatches++;
            end else begin
                due_word = frame_words_due.pop_front();
                check_field("frame_word", due_word.word, m_tdata[31:0]);
                check_field("valid_bytes", 32'(due_word.nbytes), 32'(m_tdata[34:32]));
                check_field("frame_length", 32'(due_word.flen), 32'(m_tdata[41:35]));
                check_field("last_word", 32'(due_word.last), 32'(m_tlast));
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ($urandom_range(99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        cfg_t     next;
        request_t r;
        int       row;
        int       phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct = 25;
        stall_pct = 25;
        for (row = 0; row < N_DIR; row++) begin
            if (dir_table[row].cfg != regs_now) begin
                wait_idle();
                set_config(dir_table[row].cfg, '1);
            end
            send_request(dir_table[row].req, dir_table[row].flen);
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            next = regs_now;
            case ($urandom_range(2))
                0: next.dest_mac = '0;
                1: next.dest_mac = '1;
                default: next.dest_mac = 48'({$urandom, $urandom});
            endcase
            case ($urandom_range(2))
                0: next.source_mac = '0;
                1: next.source_mac = '1;
                default: next.source_mac = 48'({$urandom, $urandom});
            endcase
            next.dest_ip = ($urandom_range(3) == 0) ? '1 : 32'($urandom);
            case (phase % 4)
                0: next.packet_mode = MODE_PTP_NSM;
                1: next.packet_mode = MODE_NTP_BASIC;
                2: next.packet_mode = MODE_PTP_DREQ;
                default: next.packet_mode = MODE_NTP_ILEAVE;
            endcase
            case ($urandom_range(2))
                0: next.ptp_domain_number = '0;
                1: next.ptp_domain_number = '1;
                default: next.ptp_domain_number = 8'($urandom);
            endcase
            next.ptp_multicast = 1'($urandom);
            wait_idle();
            set_config(next, CFG_DATA_W'({$urandom, $urandom}));

            if (phase >= N_PHASES - 2) begin
                gap_pct = 0;
                stall_pct = 0;
            end else if (phase % 3 == 0) begin
                gap_pct = 0;
                stall_pct = $urandom_range(10, 40);
            end else begin
                gap_pct = $urandom_range(10, 40);
                stall_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 40);
            end

            repeat (PHASE_ITEMS) begin
                r.source_ip = $urandom;
                r.local_ident = {$urandom, $urandom};
                r.remote_ident = {$urandom, $urandom};
                case ($urandom_range(15))
                    0: r.local_ident = '0;
                    1: r.local_ident = '1;
                    2: r.remote_ident = '0;
                    3: r.remote_ident = '1;
                    default: ;
                endcase
                if ($urandom_range(7) == 0) begin
                    r.udp_source_port = 16'($urandom);
                end else begin
                    r.udp_source_port = 16'($urandom_range(32768, 60767));
                end
                send_request(r, LEN_NONE);
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
